/* rtl/core/dau_pkg.sv */
// Shared types, constants and constant-divisor helpers for the duration
// arithmetic unit. No dependencies.
package dau_pkg;

    // Command codes; unused codes act as normalize
    typedef enum logic [2:0] {
        CMD_NORM = 3'd0,
        CMD_ADD  = 3'd1,
        CMD_SUB  = 3'd2,
        CMD_MUL  = 3'd3,
        CMD_INC  = 3'd4,
        CMD_DEC  = 3'd5
    } t_cmd;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] a_days;
        logic [15:0] a_hours;
        logic [15:0] a_minutes;
        logic [15:0] a_seconds;
        logic [15:0] b_days;
        logic [15:0] b_hours;
        logic [15:0] b_minutes;
        logic [15:0] b_seconds;
        logic [15:0] factor;
    } t_dur_in;

    typedef struct packed {
        logic [31:0] out_days;
        logic [4:0]  out_hours;
        logic [5:0]  out_minutes;
        logic [5:0]  out_seconds;
        logic        a_less;
        logic        a_equal;
        logic        a_greater;
        logic        overflow;
    } t_dur_out;

    // Compare flags of a against b
    typedef struct packed {
        logic lt;
        logic eq;
        logic gt;
    } t_cmp;

    localparam int unsigned SEC_PER_MIN  = 60;
    localparam int unsigned MIN_PER_HOUR = 60;
    localparam int unsigned HOUR_PER_DAY = 24;
    localparam int unsigned SEC_PER_HOUR = SEC_PER_MIN * MIN_PER_HOUR;
    localparam int unsigned SEC_PER_DAY  = SEC_PER_HOUR * HOUR_PER_DAY;

    // Seconds per day = 128 * 675: low 7 bits pass through the divide
    localparam int unsigned DAY_ODD      = 675;

    // Reciprocals: q = (x * RECIP) >> SHIFT, exact while x * error < 2**SHIFT
    localparam int unsigned RECIP_60     = 139811;
    localparam int unsigned SHIFT_60     = 23;
    localparam int unsigned RECIP_24     = 174763;
    localparam int unsigned SHIFT_24     = 22;
    localparam int unsigned RECIP_675    = 101806633;
    localparam int unsigned SHIFT_675    = 36;

    // Quotient by 60 of a 17-bit value
    function automatic logic [11:0] div60(input logic [16:0] x);
        logic [34:0] p;
        p = 35'(x) * 35'(RECIP_60);
        return 12'(p >> SHIFT_60);
    endfunction

    // Quotient by 24 of a 17-bit value
    function automatic logic [11:0] div24(input logic [16:0] x);
        logic [34:0] p;
        p = 35'(x) * 35'(RECIP_24);
        return 12'(p >> SHIFT_24);
    endfunction

    // Quotient by 675 of a 26-bit value
    function automatic logic [16:0] div675(input logic [25:0] x);
        logic [52:0] p;
        p = 53'(x) * 53'(RECIP_675);
        return 17'(p >> SHIFT_675);
    endfunction

endpackage

/* rtl/core/duration_arithmetic_unit.sv */
// Duration arithmetic unit: ten-stage pipeline over days/hours/minutes/seconds.
// Depends on dau_pkg for payload types, command codes and divide helpers.
//
// Usage:
//   Drive i_req and raise start; the transfer happens at any rising edge with
//   start high and busy low. busy is held low, so one command may enter every
//   cycle.
//   Each result appears on o_res for exactly one cycle with o_strobe high,
//   once its command has passed all stages; results leave in command order.
//   The receiver cannot stall the unit and needs no handshake back.
// Throughput: one command per cycle. The stages hold a chain of constant
//   divides (seconds, minutes, hours per operand; the day split of the part;
//   the final hours/minutes/seconds split) around the pair build and command.
// Operands are first normalized to (days, second-of-day) pairs; the command
//   works on those pairs, a multiply splits into days*factor and
//   second-of-day*factor, and the latter is divided back into days.
// Reset (synchronous, active low) clears the valid bits only: commands in
//   flight are dropped and no strobe follows until a new command enters.
module duration_arithmetic_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  dau_pkg::t_dur_in  i_req,
    output logic              o_strobe,
    output dau_pkg::t_dur_out o_res
);
    import dau_pkg::*;

    localparam int unsigned PIPE_DEPTH = 10;

    logic                  w_accept;
    logic [PIPE_DEPTH-1:0] r_vld;
    logic [PIPE_DEPTH-1:0] n_vld;

    // Operand fields, index 0 is a, 1 is b
    logic [15:0] w_d [2];
    logic [15:0] w_h [2];
    logic [15:0] w_m [2];
    logic [15:0] w_s [2];

    // Stage 1: seconds split
    logic [2:0]  r1_cmd;
    logic [15:0] r1_fac;
    logic [15:0] r1_d  [2];
    logic [15:0] r1_h  [2];
    logic [15:0] r1_m  [2];
    logic [11:0] r1_qs [2];
    logic [5:0]  r1_rs [2];
    logic [11:0] n1_qs [2];
    logic [5:0]  n1_rs [2];

    // Stage 2: minutes split
    logic [2:0]  r2_cmd;
    logic [15:0] r2_fac;
    logic [15:0] r2_d  [2];
    logic [15:0] r2_h  [2];
    logic [11:0] r2_qm [2];
    logic [5:0]  r2_rm [2];
    logic [5:0]  r2_rs [2];
    logic [16:0] n2_mt [2];
    logic [11:0] n2_qm [2];
    logic [5:0]  n2_rm [2];

    // Stage 3: hours split
    logic [2:0]  r3_cmd;
    logic [15:0] r3_fac;
    logic [15:0] r3_d  [2];
    logic [11:0] r3_qh [2];
    logic [4:0]  r3_rh [2];
    logic [5:0]  r3_rm [2];
    logic [5:0]  r3_rs [2];
    logic [16:0] n3_ht [2];
    logic [11:0] n3_qh [2];
    logic [4:0]  n3_rh [2];

    // Stage 4: (days, second-of-day) pairs
    logic [2:0]  r4_cmd;
    logic [15:0] r4_fac;
    logic [16:0] r4_dd [2];
    logic [16:0] r4_sd [2];
    logic [16:0] n4_dd [2];
    logic [16:0] n4_sd [2];

    // Stage 5: compare and apply command
    logic [32:0] r5_days;
    logic [32:0] r5_part;
    t_cmp        r5_cmp;
    logic [32:0] n5_days;
    logic [32:0] n5_part;
    t_cmp        n5_cmp;
    logic [17:0] w5_sum;

    // Stage 6: days carried by the second-of-day part
    logic [32:0] r6_days;
    logic [32:0] r6_part;
    logic [16:0] r6_q;
    t_cmp        r6_cmp;

    // Stage 7: day total and seconds taken by whole days
    logic [32:0] r7_days;
    logic [32:0] r7_part;
    logic [32:0] r7_qsec;
    t_cmp        r7_cmp;

    // Stage 8: second-of-day and saturation
    logic [31:0] r8_days;
    logic [16:0] r8_sod;
    logic        r8_ovf;
    t_cmp        r8_cmp;
    logic [16:0] n8_sod;

    // Stage 9: seconds and total minutes of the result
    logic [31:0] r9_days;
    logic [10:0] r9_qm;
    logic [5:0]  r9_sec;
    logic        r9_ovf;
    t_cmp        r9_cmp;
    logic [11:0] n9_qm;

    // Stage 10: output register
    t_dur_out    r_res;
    t_dur_out    n_res;
    logic [11:0] n10_hr;

    // The pipeline never stalls
    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign n_vld    = {r_vld[PIPE_DEPTH-2:0], w_accept};
    assign o_strobe = r_vld[PIPE_DEPTH-1];
    assign o_res    = r_res;

    // Advance valid bits; clear on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign w_d[0] = i_req.a_days;
    assign w_h[0] = i_req.a_hours;
    assign w_m[0] = i_req.a_minutes;
    assign w_s[0] = i_req.a_seconds;
    assign w_d[1] = i_req.b_days;
    assign w_h[1] = i_req.b_hours;
    assign w_m[1] = i_req.b_minutes;
    assign w_s[1] = i_req.b_seconds;

    // Stages 1 to 4: normalize both operands
    always_comb begin
        for (int i = 0; i < 2; i++) begin
            n1_qs[i] = div60(17'(w_s[i]));
            n1_rs[i] = 6'(17'(w_s[i]) - 17'(n1_qs[i]) * 17'(SEC_PER_MIN));
            n2_mt[i] = 17'(r1_m[i]) + 17'(r1_qs[i]);
            n2_qm[i] = div60(n2_mt[i]);
            n2_rm[i] = 6'(n2_mt[i] - 17'(n2_qm[i]) * 17'(MIN_PER_HOUR));
            n3_ht[i] = 17'(r2_h[i]) + 17'(r2_qm[i]);
            n3_qh[i] = div24(n3_ht[i]);
            n3_rh[i] = 5'(n3_ht[i] - 17'(n3_qh[i]) * 17'(HOUR_PER_DAY));
            n4_dd[i] = 17'(r3_d[i]) + 17'(r3_qh[i]);
            n4_sd[i] = 17'(r3_rh[i]) * 17'(SEC_PER_HOUR)
                     + 17'(r3_rm[i]) * 17'(SEC_PER_MIN) + 17'(r3_rs[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        r1_cmd <= i_req.cmd;
        r1_fac <= i_req.factor;
        r2_cmd <= r1_cmd;
        r2_fac <= r1_fac;
        r3_cmd <= r2_cmd;
        r3_fac <= r2_fac;
        r4_cmd <= r3_cmd;
        r4_fac <= r3_fac;
        for (int i = 0; i < 2; i++) begin
            r1_d[i]  <= w_d[i];
            r1_h[i]  <= w_h[i];
            r1_m[i]  <= w_m[i];
            r1_qs[i] <= n1_qs[i];
            r1_rs[i] <= n1_rs[i];
            r2_d[i]  <= r1_d[i];
            r2_h[i]  <= r1_h[i];
            r2_qm[i] <= n2_qm[i];
            r2_rm[i] <= n2_rm[i];
            r2_rs[i] <= r1_rs[i];
            r3_d[i]  <= r2_d[i];
            r3_qh[i] <= n3_qh[i];
            r3_rh[i] <= n3_rh[i];
            r3_rm[i] <= r2_rm[i];
            r3_rs[i] <= r2_rs[i];
            r4_dd[i] <= n4_dd[i];
            r4_sd[i] <= n4_sd[i];
        end
    end

    // Stage 5: compare totals and apply the command on (days, second-of-day)
    always_comb begin
        n5_cmp.lt = {r4_dd[0], r4_sd[0]} <  {r4_dd[1], r4_sd[1]};
        n5_cmp.eq = {r4_dd[0], r4_sd[0]} == {r4_dd[1], r4_sd[1]};
        n5_cmp.gt = {r4_dd[0], r4_sd[0]} >  {r4_dd[1], r4_sd[1]};
        w5_sum    = 18'(r4_sd[0]) + 18'(r4_sd[1]);
        n5_days   = 33'(r4_dd[0]);
        n5_part   = 33'(r4_sd[0]);
        case (r4_cmd)
            CMD_ADD: begin
                if (w5_sum >= 18'(SEC_PER_DAY)) begin
                    n5_days = 33'(r4_dd[0]) + 33'(r4_dd[1]) + 33'd1;
                    n5_part = 33'(w5_sum - 18'(SEC_PER_DAY));
                end else begin
                    n5_days = 33'(r4_dd[0]) + 33'(r4_dd[1]);
                    n5_part = 33'(w5_sum);
                end
            end
            CMD_SUB: begin
                if (!n5_cmp.gt) begin
                    n5_days = '0;
                    n5_part = '0;
                end else if (r4_sd[0] >= r4_sd[1]) begin
                    n5_days = 33'(r4_dd[0] - r4_dd[1]);
                    n5_part = 33'(r4_sd[0] - r4_sd[1]);
                end else begin
                    n5_days = 33'(r4_dd[0] - r4_dd[1] - 17'd1);
                    n5_part = 33'(18'(r4_sd[0]) + 18'(SEC_PER_DAY) - 18'(r4_sd[1]));
                end
            end
            CMD_MUL: begin
                n5_days = 33'(r4_dd[0]) * 33'(r4_fac);
                n5_part = 33'(r4_sd[0]) * 33'(r4_fac);
            end
            CMD_INC: begin
                if (r4_sd[0] == 17'(SEC_PER_DAY - 1)) begin
                    n5_days = 33'(r4_dd[0]) + 33'd1;
                    n5_part = '0;
                end else begin
                    n5_part = 33'(r4_sd[0] + 17'd1);
                end
            end
            CMD_DEC: begin
                if (r4_sd[0] != '0) begin
                    n5_part = 33'(r4_sd[0] - 17'd1);
                end else if (r4_dd[0] != '0) begin
                    n5_days = 33'(r4_dd[0] - 17'd1);
                    n5_part = 33'(SEC_PER_DAY - 1);
                end else begin
                    n5_days = '0;
                    n5_part = '0;
                end
            end
            default: begin
                n5_days = 33'(r4_dd[0]);
                n5_part = 33'(r4_sd[0]);
            end
        endcase
    end

    // Stage 8: drop whole days from the part, saturate the day count
    always_comb begin
        n8_sod = 17'(r7_part - r7_qsec);
        if (r7_days[32]) begin
            n8_sod = 17'(SEC_PER_DAY - 1);
        end
    end

    // Stages 9 and 10: split second-of-day into h/m/s
    assign n9_qm  = div60(r8_sod);
    assign n10_hr = div60(17'(r9_qm));

    always_comb begin
        n_res.out_days    = r9_days;
        n_res.out_hours   = 5'(n10_hr);
        n_res.out_minutes = 6'(12'(r9_qm) - n10_hr * 12'(MIN_PER_HOUR));
        n_res.out_seconds = r9_sec;
        n_res.a_less      = r9_cmp.lt;
        n_res.a_equal     = r9_cmp.eq;
        n_res.a_greater   = r9_cmp.gt;
        n_res.overflow    = r9_ovf;
    end

    // Stages 5 to 10 payload registers
    always_ff @(posedge i_clk) begin
        r5_days <= n5_days;
        r5_part <= n5_part;
        r5_cmp  <= n5_cmp;

        // Part is below 86400 * 2**16; divide its upper bits by 675
        r6_days <= r5_days;
        r6_part <= r5_part;
        r6_q    <= div675(r5_part[32:7]);
        r6_cmp  <= r5_cmp;

        r7_days <= r6_days + 33'(r6_q);
        r7_part <= r6_part;
        r7_qsec <= 33'(r6_q) * 33'(SEC_PER_DAY);
        r7_cmp  <= r6_cmp;

        r8_days <= r7_days[32] ? '1 : r7_days[31:0];
        r8_sod  <= n8_sod;
        r8_ovf  <= r7_days[32];
        r8_cmp  <= r7_cmp;

        r9_days <= r8_days;
        r9_qm   <= 11'(n9_qm);
        r9_sec  <= 6'(r8_sod - 17'(n9_qm) * 17'(SEC_PER_MIN));
        r9_ovf  <= r8_ovf;
        r9_cmp  <= r8_cmp;

        r_res   <= n_res;
    end

    // Every accepted command yields a strobe after the pipeline latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##PIPE_DEPTH o_strobe)
        else $error("accepted command produced no result strobe");

    // Exactly one compare flag per result
    a_cmp_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $onehot({o_res.a_less, o_res.a_equal, o_res.a_greater}))
        else $error("compare flags not one-hot");

    // Result fields are normalized
    a_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_res.out_hours < 5'd24) && (o_res.out_minutes < 6'd60)
                     && (o_res.out_seconds < 6'd60))
        else $error("result not normalized");

    // Saturation gives the largest duration
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.overflow) |-> (o_res.out_days == '1)
            && (o_res.out_hours == 5'd23) && (o_res.out_minutes == 6'd59)
            && (o_res.out_seconds == 6'd59))
        else $error("overflow result not saturated");

endmodule
